### hdl/bcr_pkg.sv
// Shared types and sizing constants for the two-ball collision pipeline.
package bcr_pkg;

  localparam int unsigned VW       = 32;  // value field width
  localparam int unsigned DW       = 33;  // centre difference and its magnitude
  localparam int unsigned POSW     = 6;   // leading-one position of a DW-bit value
  localparam int unsigned UNIT     = 30;  // fraction bits of the unit vector
  localparam int unsigned NW       = 30;  // normalized magnitude width
  localparam int unsigned NSQW     = 61;  // sum of two squared magnitudes
  localparam int unsigned SQW      = 62;  // square root working width
  localparam int unsigned SQ_STEPS = 31;  // one result bit per stage
  localparam int unsigned LW       = 31;  // root width
  localparam int unsigned QW       = 31;  // quotient width, one bit per stage
  localparam int unsigned RW       = 32;  // partial remainder width
  localparam int unsigned RSTW     = 17;  // restitution register width
  localparam int unsigned KW       = 18;  // (1 + e) in Q2.16

  localparam logic [RSTW-1:0] RESTITUTION_ONE = RSTW'(65536);

  typedef logic signed [VW-1:0] val_t;

  typedef struct packed {
    val_t v1x;
    val_t v1y;
    val_t v2x;
    val_t v2y;
    logic neg_x;
    logic neg_y;
    logic coincide;
  } item_t;

endpackage

### hdl/bcr_front.sv
// Centre difference, magnitude normalization and sum of squares.
module bcr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  bcr_pkg::item_t         item_i,
  input  bcr_pkg::val_t          p1x_i,
  input  bcr_pkg::val_t          p1y_i,
  input  bcr_pkg::val_t          p2x_i,
  input  bcr_pkg::val_t          p2y_i,
  output logic                   valid_o,
  output bcr_pkg::item_t         item_o,
  output logic [bcr_pkg::NW-1:0] ux_o,
  output logic [bcr_pkg::NW-1:0] uy_o,
  output logic [bcr_pkg::NSQW-1:0] nsq_o
);
  import bcr_pkg::*;

  localparam logic [POSW-1:0] TOP_POS = POSW'(NW - 1);

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        ax, ay, big;
  logic [POSW-1:0]      pos_d;
  logic [NW-1:0]        sx_d, sy_d;
  logic [NSQW-1:0]      nsq_d;
  item_t                item_a;

  logic            va_q, vb_q, vc_q, vd_q;
  item_t           ia_q, ib_q, ic_q, id_q;
  logic [DW-1:0]   xa_q, ya_q, xb_q, yb_q;
  logic [POSW-1:0] pos_q;
  logic [NW-1:0]   xc_q, yc_q, xd_q, yd_q;
  logic [NSQW-1:0] nsq_q;

  always_comb begin
    dx = DW'(p2x_i) - DW'(p1x_i);
    dy = DW'(p2y_i) - DW'(p1y_i);
    ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    item_a          = item_i;
    item_a.neg_x    = dx[DW-1];
    item_a.neg_y    = dy[DW-1];
    item_a.coincide = (dx == '0) && (dy == '0);
  end

  // leading one of the larger magnitude
  always_comb begin
    big   = (xa_q > ya_q) ? xa_q : ya_q;
    pos_d = '0;
    for (int i = 0; i < DW; i++) begin
      if (big[i]) pos_d = POSW'(i);
    end
  end

  // bring the larger magnitude into [2^29, 2^30), truncating on the right
  always_comb begin
    if (pos_q > TOP_POS) begin
      sx_d = NW'(xb_q >> (pos_q - TOP_POS));
      sy_d = NW'(yb_q >> (pos_q - TOP_POS));
    end else begin
      sx_d = NW'(xb_q << (TOP_POS - pos_q));
      sy_d = NW'(yb_q << (TOP_POS - pos_q));
    end
  end

  assign nsq_d = (NSQW'(xc_q) * NSQW'(xc_q)) + (NSQW'(yc_q) * NSQW'(yc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ia_q  <= item_a;
      xa_q  <= ax;
      ya_q  <= ay;
      ib_q  <= ia_q;
      xb_q  <= xa_q;
      yb_q  <= ya_q;
      pos_q <= pos_d;
      ic_q  <= ib_q;
      xc_q  <= sx_d;
      yc_q  <= sy_d;
      id_q  <= ic_q;
      xd_q  <= xc_q;
      yd_q  <= yc_q;
      nsq_q <= nsq_d;
    end
  end

  assign valid_o = vd_q;
  assign item_o  = id_q;
  assign ux_o    = xd_q;
  assign uy_o    = yd_q;
  assign nsq_o   = nsq_q;

endmodule

### hdl/bcr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module bcr_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  bcr_pkg::item_t           item_i,
  input  logic [bcr_pkg::NW-1:0]   ux_i,
  input  logic [bcr_pkg::NW-1:0]   uy_i,
  input  logic [bcr_pkg::NSQW-1:0] nsq_i,
  output logic                     valid_o,
  output bcr_pkg::item_t           item_o,
  output logic [bcr_pkg::NW-1:0]   ux_o,
  output logic [bcr_pkg::NW-1:0]   uy_o,
  output logic [bcr_pkg::LW-1:0]   len_o
);
  import bcr_pkg::*;

  logic           valid_q [SQ_STEPS];
  item_t          item_q  [SQ_STEPS];
  logic [NW-1:0]  ux_q    [SQ_STEPS];
  logic [NW-1:0]  uy_q    [SQ_STEPS];
  logic [SQW-1:0] n_q     [SQ_STEPS];
  logic [SQW-1:0] r_q     [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));

    logic           v_in;
    item_t          it_in;
    logic [NW-1:0]  x_in, y_in;
    logic [SQW-1:0] n_in, r_in, rb, n_d, r_d;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign it_in = item_i;
      assign x_in  = ux_i;
      assign y_in  = uy_i;
      assign n_in  = SQW'(nsq_i);
      assign r_in  = '0;
    end else begin : g_next
      assign v_in  = valid_q[k-1];
      assign it_in = item_q[k-1];
      assign x_in  = ux_q[k-1];
      assign y_in  = uy_q[k-1];
      assign n_in  = n_q[k-1];
      assign r_in  = r_q[k-1];
    end

    always_comb begin
      rb = r_in + BIT;
      if (n_in >= rb) begin
        n_d = n_in - rb;
        r_d = (r_in >> 1) + BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= it_in;
        ux_q[k]   <= x_in;
        uy_q[k]   <= y_in;
        n_q[k]    <= n_d;
        r_q[k]    <= r_d;
      end
    end
  end

  assign valid_o = valid_q[SQ_STEPS-1];
  assign item_o  = item_q[SQ_STEPS-1];
  assign ux_o    = ux_q[SQ_STEPS-1];
  assign uy_o    = uy_q[SQ_STEPS-1];
  assign len_o   = r_q[SQ_STEPS-1][LW-1:0];

endmodule

### hdl/bcr_divide.sv
// Pipelined restoring division for the Q1.30 cosine and sine, signs applied last.
module bcr_divide (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  bcr_pkg::item_t         item_i,
  input  logic [bcr_pkg::NW-1:0] ux_i,
  input  logic [bcr_pkg::NW-1:0] uy_i,
  input  logic [bcr_pkg::LW-1:0] len_i,
  output logic                   valid_o,
  output bcr_pkg::item_t         item_o,
  output bcr_pkg::val_t          cos_o,
  output bcr_pkg::val_t          sin_o
);
  import bcr_pkg::*;

  logic          valid_q [QW];
  item_t         item_q  [QW];
  logic [LW-1:0] len_q   [QW];
  logic [RW-1:0] remx_q  [QW];
  logic [RW-1:0] remy_q  [QW];
  logic [QW-1:0] qx_q    [QW];
  logic [QW-1:0] qy_q    [QW];

  logic  vout_q;
  item_t iout_q;
  val_t  cos_q, sin_q;

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic          v_in;
    item_t         it_in;
    logic [LW-1:0] l_in;
    logic [RW-1:0] rx_in, ry_in;
    logic [QW-1:0] qx_in, qy_in;
    logic          bx_in, by_in;
    logic [RW:0]   rx2, ry2;
    logic          gx, gy;

    // the dividend is the magnitude shifted up by UNIT: its low bit enters first
    if (j == 0) begin : g_first
      assign v_in  = valid_i;
      assign it_in = item_i;
      assign l_in  = len_i;
      assign rx_in = RW'(ux_i >> 1);
      assign ry_in = RW'(uy_i >> 1);
      assign qx_in = '0;
      assign qy_in = '0;
      assign bx_in = ux_i[0];
      assign by_in = uy_i[0];
    end else begin : g_next
      assign v_in  = valid_q[j-1];
      assign it_in = item_q[j-1];
      assign l_in  = len_q[j-1];
      assign rx_in = remx_q[j-1];
      assign ry_in = remy_q[j-1];
      assign qx_in = qx_q[j-1];
      assign qy_in = qy_q[j-1];
      assign bx_in = 1'b0;
      assign by_in = 1'b0;
    end

    assign rx2 = {rx_in, bx_in};
    assign ry2 = {ry_in, by_in};
    assign gx  = rx2 >= (RW + 1)'(l_in);
    assign gy  = ry2 >= (RW + 1)'(l_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[j] <= it_in;
        len_q[j]  <= l_in;
        remx_q[j] <= gx ? RW'(rx2 - (RW + 1)'(l_in)) : RW'(rx2);
        remy_q[j] <= gy ? RW'(ry2 - (RW + 1)'(l_in)) : RW'(ry2);
        qx_q[j]   <= {qx_in[QW-2:0], gx};
        qy_q[j]   <= {qy_in[QW-2:0], gy};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= valid_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      iout_q <= item_q[QW-1];
      cos_q  <= item_q[QW-1].neg_x ? -VW'(qx_q[QW-1]) : VW'(qx_q[QW-1]);
      sin_q  <= item_q[QW-1].neg_y ? -VW'(qy_q[QW-1]) : VW'(qy_q[QW-1]);
    end
  end

  assign valid_o = vout_q;
  assign item_o  = iout_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

### hdl/bcr_rotate.sv
// Projection onto the centre line, restitution, rotation back and saturation.
module bcr_rotate (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  bcr_pkg::item_t         item_i,
  input  bcr_pkg::val_t          cos_i,
  input  bcr_pkg::val_t          sin_i,
  input  logic [bcr_pkg::KW-1:0] k_i,
  output logic                   valid_o,
  output bcr_pkg::val_t          v1x_o,
  output bcr_pkg::val_t          v1y_o,
  output bcr_pkg::val_t          v2x_o,
  output bcr_pkg::val_t          v2y_o,
  output logic                   coincide_o
);
  import bcr_pkg::*;

  localparam int unsigned PW  = 2 * VW;      // projection products
  localparam int unsigned AW  = 34;          // projected components
  localparam int unsigned FW  = AW + 1 + KW + 1;
  localparam int unsigned KSH = 17;
  localparam int unsigned TW  = 36;          // components after restitution
  localparam int unsigned BW  = TW + VW;     // rotation products
  localparam int unsigned SW  = BW + 1 - UNIT;

  localparam logic signed [PW:0]   HALF_P = (PW + 1)'(1) << (UNIT - 1);
  localparam logic signed [FW:0]   HALF_K = (FW + 1)'(1) << (KSH - 1);
  localparam logic signed [BW:0]   HALF_B = (BW + 1)'(1) << (UNIT - 1);
  localparam logic signed [VW-1:0] VMAX   = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN   = {1'b1, {(VW - 1){1'b0}}};

  function automatic val_t sat(input logic [SW-1:0] x);
    if ((&x[SW-1:VW-1]) || !(|x[SW-1:VW-1])) begin
      return x[VW-1:0];
    end
    return x[SW-1] ? VMIN : VMAX;
  endfunction

  logic  v_q [6];
  item_t i_q [5];
  val_t  c_q [4];
  val_t  s_q [4];

  // stage 1: projection products
  logic signed [PW-1:0] p1c_q, p1s_q, q1c_q, q1s_q, p2c_q, p2s_q, q2c_q, q2s_q;
  // stage 2: along and across components
  logic signed [PW:0]   a1w, a2w, b1w, b2w;
  logic signed [AW-1:0] a1_q, a2_q, b1_q, b2_q, a1c_q, a2c_q, b1c_q, b2c_q;
  logic signed [AW-1:0] b1d_q, b2d_q;
  // stage 3: restitution product
  logic signed [AW:0]   diff;
  logic signed [KW:0]   kw;
  logic signed [FW-1:0] kp_q;
  // stage 4: new along components
  logic signed [FW:0]   kr;
  logic signed [TW-1:0] dd, t1_q, t2_q;
  // stage 5: rotation products
  logic signed [BW-1:0] t1c_q, t1s_q, b1c2_q, b1s_q, t2c_q, t2s_q, b2c2_q, b2s_q;
  // stage 6: outputs
  logic signed [BW:0]   n1x, n1y, n2x, n2y;
  val_t                 o1x_q, o1y_q, o2x_q, o2y_q;
  logic                 oc_q;

  always_comb begin
    a1w  = (PW + 1)'(p1c_q) + (PW + 1)'(p1s_q) + HALF_P;
    a2w  = (PW + 1)'(p2c_q) + (PW + 1)'(p2s_q) + HALF_P;
    b1w  = (PW + 1)'(q1c_q) - (PW + 1)'(q1s_q) + HALF_P;
    b2w  = (PW + 1)'(q2c_q) - (PW + 1)'(q2s_q) + HALF_P;
    diff = (AW + 1)'(a1_q) - (AW + 1)'(a2_q);
    kw   = $signed({1'b0, k_i});
    kr   = (FW + 1)'(kp_q) + HALF_K;
    dd   = kr[KSH+TW-1:KSH];
    n1x  = (BW + 1)'(t1c_q) - (BW + 1)'(b1s_q) + HALF_B;
    n1y  = (BW + 1)'(t1s_q) + (BW + 1)'(b1c2_q) + HALF_B;
    n2x  = (BW + 1)'(t2c_q) - (BW + 1)'(b2s_q) + HALF_B;
    n2y  = (BW + 1)'(t2s_q) + (BW + 1)'(b2c2_q) + HALF_B;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < 6; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i_q[0] <= item_i;
      c_q[0] <= cos_i;
      s_q[0] <= sin_i;
      for (int i = 1; i < 5; i++) i_q[i] <= i_q[i-1];
      for (int i = 1; i < 4; i++) begin
        c_q[i] <= c_q[i-1];
        s_q[i] <= s_q[i-1];
      end
      p1c_q  <= item_i.v1x * cos_i;
      p1s_q  <= item_i.v1y * sin_i;
      q1c_q  <= item_i.v1y * cos_i;
      q1s_q  <= item_i.v1x * sin_i;
      p2c_q  <= item_i.v2x * cos_i;
      p2s_q  <= item_i.v2y * sin_i;
      q2c_q  <= item_i.v2y * cos_i;
      q2s_q  <= item_i.v2x * sin_i;
      a1_q   <= a1w[UNIT+AW-1:UNIT];
      a2_q   <= a2w[UNIT+AW-1:UNIT];
      b1_q   <= b1w[UNIT+AW-1:UNIT];
      b2_q   <= b2w[UNIT+AW-1:UNIT];
      a1c_q  <= a1_q;
      a2c_q  <= a2_q;
      b1c_q  <= b1_q;
      b2c_q  <= b2_q;
      kp_q   <= diff * kw;
      b1d_q  <= b1c_q;
      b2d_q  <= b2c_q;
      t1_q   <= TW'(a1c_q) - dd;
      t2_q   <= TW'(a2c_q) + dd;
      t1c_q  <= t1_q * c_q[3];
      t1s_q  <= t1_q * s_q[3];
      b1c2_q <= b1d_q * c_q[3];
      b1s_q  <= b1d_q * s_q[3];
      t2c_q  <= t2_q * c_q[3];
      t2s_q  <= t2_q * s_q[3];
      b2c2_q <= b2d_q * c_q[3];
      b2s_q  <= b2d_q * s_q[3];
      // pass the velocities through when the centres coincide
      if (i_q[4].coincide) begin
        o1x_q <= i_q[4].v1x;
        o1y_q <= i_q[4].v1y;
        o2x_q <= i_q[4].v2x;
        o2y_q <= i_q[4].v2y;
      end else begin
        o1x_q <= sat(n1x[BW:UNIT]);
        o1y_q <= sat(n1y[BW:UNIT]);
        o2x_q <= sat(n2x[BW:UNIT]);
        o2y_q <= sat(n2y[BW:UNIT]);
      end
      oc_q <= i_q[4].coincide;
    end
  end

  assign valid_o    = v_q[5];
  assign v1x_o      = o1x_q;
  assign v1y_o      = o1y_q;
  assign v2x_o      = o2x_q;
  assign v2y_o      = o2y_q;
  assign coincide_o = oc_q;

endmodule

### hdl/two_ball_collision_response.sv
// Two-ball collision response: top level with input unpacking, register and output skid.
// One ball pair enters per clock while the pipeline is not held and passes through 74
// registers before its result word is offered: four front stages, 31 square root
// stages (one root bit each), 32 division stages (one quotient bit each plus the sign
// stage), six rotation stages and the output register. The output register and a
// one-word skid stage keep the input side taking words while a result waits; the
// pipeline holds only when both are full.
module two_ball_collision_response (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bcr_pkg::RSTW-1:0]   cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // first_pos_x, first_pos_y, first_vel_x, first_vel_y,
  // second_pos_x, second_pos_y, second_vel_x, second_vel_y
  input  logic [8*bcr_pkg::VW-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
  output logic [4*bcr_pkg::VW-1:0]   m_axis_tdata,
  // centres_coincide
  output logic                       m_axis_tuser
);
  import bcr_pkg::*;

  logic [RSTW-1:0] restitution_q;
  logic [RSTW-1:0] e_lim;
  logic [KW-1:0]   k_fac;
  logic            en;
  item_t           in_item;
  val_t            p1x, p1y, p2x, p2y;

  logic          fr_valid, sq_valid, dv_valid, rt_valid, rt_coin;
  item_t         fr_item, sq_item, dv_item;
  logic [NW-1:0] fr_ux, fr_uy, sq_ux, sq_uy;
  logic [NSQW-1:0] fr_nsq;
  logic [LW-1:0] sq_len;
  val_t          dv_cos, dv_sin, r1x, r1y, r2x, r2y;

  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [4*VW-1:0]   out_data_q, out_data_d, skid_data_q, skid_data_d, rt_data;
  logic              out_user_q, out_user_d, skid_user_q, skid_user_d;
  logic              take, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= RESTITUTION_ONE;
    end else if (cfg_we_i) begin
      restitution_q <= cfg_wdata_i;
    end
  end

  // clamp e to 1.0 and form (1 + e) in Q2.16
  assign e_lim = (restitution_q > RESTITUTION_ONE) ? RESTITUTION_ONE : restitution_q;
  assign k_fac = KW'(RESTITUTION_ONE) + KW'(e_lim);

  assign p1x = s_axis_tdata[0*VW +: VW];
  assign p1y = s_axis_tdata[1*VW +: VW];
  assign p2x = s_axis_tdata[4*VW +: VW];
  assign p2y = s_axis_tdata[5*VW +: VW];

  always_comb begin
    in_item          = '0;
    in_item.v1x      = s_axis_tdata[2*VW +: VW];
    in_item.v1y      = s_axis_tdata[3*VW +: VW];
    in_item.v2x      = s_axis_tdata[6*VW +: VW];
    in_item.v2y      = s_axis_tdata[7*VW +: VW];
  end

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  bcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (in_item),
    .p1x_i   (p1x),
    .p1y_i   (p1y),
    .p2x_i   (p2x),
    .p2y_i   (p2y),
    .valid_o (fr_valid),
    .item_o  (fr_item),
    .ux_o    (fr_ux),
    .uy_o    (fr_uy),
    .nsq_o   (fr_nsq)
  );

  bcr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .item_i  (fr_item),
    .ux_i    (fr_ux),
    .uy_i    (fr_uy),
    .nsq_i   (fr_nsq),
    .valid_o (sq_valid),
    .item_o  (sq_item),
    .ux_o    (sq_ux),
    .uy_o    (sq_uy),
    .len_o   (sq_len)
  );

  bcr_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .item_i  (sq_item),
    .ux_i    (sq_ux),
    .uy_i    (sq_uy),
    .len_i   (sq_len),
    .valid_o (dv_valid),
    .item_o  (dv_item),
    .cos_o   (dv_cos),
    .sin_o   (dv_sin)
  );

  bcr_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_valid),
    .item_i     (dv_item),
    .cos_i      (dv_cos),
    .sin_i      (dv_sin),
    .k_i        (k_fac),
    .valid_o    (rt_valid),
    .v1x_o      (r1x),
    .v1y_o      (r1y),
    .v2x_o      (r2x),
    .v2y_o      (r2y),
    .coincide_o (rt_coin)
  );

  assign rt_data = {r2y, r2x, r1y, r1x};
  assign take    = out_valid_q && m_axis_tready;
  assign push    = en && rt_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    skid_user_d  = skid_user_q;
    if (skid_valid_q) begin
      if (take) begin
        out_data_d   = skid_data_q;
        out_user_d   = skid_user_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_data_d  = rt_data;
        out_user_d  = rt_coin;
      end else begin
        // hold the new word aside while the output word waits
        skid_valid_d = 1'b1;
        skid_data_d  = rt_data;
        skid_user_d  = rt_coin;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
    skid_data_q <= skid_data_d;
    skid_user_q <= skid_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && push) |=> skid_valid_q)
    else $error("result word dropped while output stalled");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready) |=> (out_valid_q && !skid_valid_q))
    else $error("skid word not moved to output");
`endif

endmodule

### tb/tb.sv
// Testbench for the two-ball collision response block: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    word_t v1x;
    word_t v1y;
    word_t v2x;
    word_t v2y;
    logic  coincide;
  } response_t;

  // floor((x + 2^(k-1)) / 2^k)
  function automatic longint rnd_shift(longint x, int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic word_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return word_t'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic response_t collide(logic [255:0] w, logic [16:0] rest);
    response_t res;
    longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, dx, dy;
    longint unsigned ux, uy, big, len;
    longint c, s, a1, a2, b1, b2, t1, t2, dlt, f;
    p1x = word_t'(w[31:0]);    p1y = word_t'(w[63:32]);
    v1x = word_t'(w[95:64]);   v1y = word_t'(w[127:96]);
    p2x = word_t'(w[159:128]); p2y = word_t'(w[191:160]);
    v2x = word_t'(w[223:192]); v2y = word_t'(w[255:224]);
    dx = p2x - p1x;
    dy = p2y - p1y;
    if (dx == 0 && dy == 0) begin
      res.v1x = word_t'(v1x); res.v1y = word_t'(v1y);
      res.v2x = word_t'(v2x); res.v2y = word_t'(v2y);
      res.coincide = 1'b1;
      return res;
    end
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    big = ux > uy ? ux : uy;
    while (big >= (64'd1 << 30)) begin
      ux >>= 1; uy >>= 1; big >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      ux <<= 1; uy <<= 1; big <<= 1;
    end
    len = int_sqrt(ux * ux + uy * uy);
    c = longint'((ux << 30) / len);
    s = longint'((uy << 30) / len);
    if (dx < 0) c = -c;
    if (dy < 0) s = -s;
    a1 = rnd_shift(v1x * c + v1y * s, 30);
    a2 = rnd_shift(v2x * c + v2y * s, 30);
    b1 = rnd_shift(v1y * c - v1x * s, 30);
    b2 = rnd_shift(v2y * c - v2x * s, 30);
    f = 65536 + ((rest > 17'd65536) ? 65536 : longint'(rest));
    dlt = rnd_shift(f * (a1 - a2), 17);
    t1 = a1 - dlt;
    t2 = a2 + dlt;
    res.v1x = clamp32(rnd_shift(t1 * c - b1 * s, 30));
    res.v1y = clamp32(rnd_shift(t1 * s + b1 * c, 30));
    res.v2x = clamp32(rnd_shift(t2 * c - b2 * s, 30));
    res.v2y = clamp32(rnd_shift(t2 * s + b2 * c, 30));
    res.coincide = 1'b0;
    return res;
  endfunction

  class collision_board;
    response_t   pending_q[$];
    logic [16:0] rest;
    int          errors;

    function void note_pair(logic [255:0] w);
      pending_q.push_back(collide(w, rest));
    endfunction

    function void check_response(logic [127:0] data, logic usr);
      response_t want, got;
      got = {data[31:0], data[63:32], data[95:64], data[127:96], usr};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h user %b", data, usr);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                   want.v1x, want.v1y, want.v2x, want.v2y, want.coincide,
                   got.v1x, got.v1y, got.v2x, got.v2y, got.coincide);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [16:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  collision_board board = new();
  bit           stim_done = 1'b0;
  int unsigned  cycles = 0;
  int unsigned  resp_count = 0;
  int unsigned  resp_seen = 0;
  int unsigned  out_wait = 0;

  two_ball_collision_response uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_response(m_axis_tdata, m_axis_tuser);
      resp_count <= resp_count + 1;
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // draw a fresh wait for every output word, then hold ready until it is taken
  always @(negedge clk_i) begin
    if (resp_seen != resp_count) begin
      resp_seen = resp_count;
      out_wait = $urandom_range(0, 15);
    end
    if (out_wait != 0) begin
      out_wait = out_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_restitution(logic [16:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.rest = value;
  endtask

  task automatic send_pair(logic [255:0] w, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (!no_gap && $urandom_range(0, 1)) gap = 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return word_t'($urandom_range(0, 2000)) - 1000;
      3: return word_t'($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic logic [255:0] rand_pair();
    logic [255:0] w;
    for (int i = 0; i < 8; i++) w[i*32 +: 32] = rand_word();
    // sometimes make the centres coincide, or nearly so
    case ($urandom_range(0, 9))
      0: w[191:128] = w[63:0];
      1: w[191:128] = {w[63:32] + word_t'($urandom_range(0, 2)),
                       w[31:0] - word_t'($urandom_range(0, 2))};
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [16:0] settings[5];
    settings = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd65537};
    board.rest = 17'd65536;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset restitution, extremes, coinciding centres, axes, saturation
    send_pair('0, 1'b1);
    send_pair({8{32'sh7fffffff}}, 1'b1);
    send_pair({8{32'sh80000000}}, 1'b1);
    send_pair({32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000}, 1'b0);
    send_pair({32'sh0, 32'sh0, 32'sh7fffffff, 32'sh80000000,
               32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}, 1'b0);
    send_pair({32'sh0, 32'sh0, 32'shfff0000, 32'sh10000,
               32'sh0, 32'sh0, 32'sh10000, 32'sh0}, 1'b0);
    send_pair({32'sh0, 32'sh0, 32'sh0, 32'sh10000,
               32'sh0, 32'sh1, 32'sh0, 32'sh0}, 1'b0);
    send_pair({32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
               32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1'b0);
    send_pair({32'sh12345678, 32'sh5, 32'shffff0000, 32'sh1,
               32'sh12345678, 32'sh5, 32'sh10000, 32'sh0}, 1'b0);
    send_pair({32'shffffffff, 32'shffffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh0, 32'sh0, 32'sh80000000, 32'sh80000000}, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_restitution(settings[ph]);
      for (int n = 0; n < 190; n++) send_pair(rand_pair(), 1'b0);
    end
    stim_done = 1'b1;
    drain();
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
